// ===== sv/opl_sb_pkg.sv =====
`default_nettype none

package opl_sb_pkg;

    // Access handlers selected by the dispatch tables
    typedef enum logic [3:0] {
        H_NONE         = 4'd0,
        H_IGNORE       = 4'd1,
        H_FM_READ      = 4'd2,
        H_FM_ADDR      = 4'd3,
        H_FM_DATA      = 4'd4,
        H_HI_READ      = 4'd5,
        H_HI_LOW_ADDR  = 4'd6,
        H_HI_HIGH_ADDR = 4'd7,
        H_HI_DATA      = 4'd8,
        H_DSP_READ     = 4'd9,
        H_MIXER_WRITE  = 4'd10,
        H_DSP_RESET    = 4'd11,
        H_DSP_WRITE    = 4'd12,
        H_DSP_WBUF     = 4'd13,
        H_DSP_AVAIL    = 4'd14
    } handler_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SB_BASE = 2'd0,
        CFG_OPL3    = 2'd1,
        CFG_DELAY   = 2'd2
    } cfg_index_t;

    localparam logic [15:0] FM_BASE_PORT    = 16'h0388;
    localparam logic [3:0]  LPT_CTRL_ADDR   = 4'd13;
    localparam logic [3:0]  LPT_CTRL_DATA   = 4'd12;
    localparam logic [3:0]  LPT_CTRL_HIGH   = 4'd5;
    localparam logic [5:0]  DLY_SHORT       = 6'd6;
    localparam logic [5:0]  DLY_LONG        = 6'd35;
    localparam logic [8:0]  TIMER_CTRL_ADDR = 9'd4;

    localparam logic [7:0]  T1_MASK         = 8'hC1;
    localparam logic [7:0]  T1_MATCH        = 8'h01;
    localparam logic [7:0]  T1_FLAGS        = 8'hC0;
    localparam logic [7:0]  T2_MASK         = 8'hA2;
    localparam logic [7:0]  T2_MATCH        = 8'h02;
    localparam logic [7:0]  T2_FLAGS        = 8'hA0;
    localparam logic [7:0]  OPL2_ID_BITS    = 8'h06;

    localparam logic [7:0]  DSP_RESET_REPLY = 8'hAA;
    localparam logic [7:0]  DSP_CMD_VERSION = 8'hE1;
    localparam logic [7:0]  DSP_CMD_IDENT   = 8'hE0;
    localparam logic [7:0]  DSP_CMD_DIRECT  = 8'h10;
    localparam logic [7:0]  DSP_CMD_MIDI    = 8'h38;
    localparam logic [7:0]  DSP_CMD_TCONST  = 8'h40;
    localparam logic [7:0]  DSP_CMD_IRQ     = 8'hF2;
    localparam logic [7:0]  VER_OPL3_MAJOR  = 8'd3;
    localparam logic [7:0]  VER_OPL3_MINOR  = 8'd2;
    localparam logic [7:0]  VER_OPL2_MAJOR  = 8'd1;
    localparam logic [7:0]  VER_OPL2_MINOR  = 8'd5;
    localparam logic [7:0]  AVAIL_FLAGS     = 8'hFF;

    // One result word
    typedef struct packed {
        logic       claimed;
        logic [7:0] read_data;
        logic       lpt_write;
        logic [7:0] lpt_data;
        logic [3:0] lpt_control;
        logic [5:0] settle_delay;
        logic       raise_irq;
    } result_t;

    // Fixed FM ports 0x388..0x38B
    function automatic handler_t fixed_lookup(input logic [1:0] idx, input logic wr);
        handler_t h;
        begin
            case (idx)
                2'd0:    h = wr ? H_FM_ADDR : H_FM_READ;
                2'd1:    h = wr ? H_FM_DATA : H_FM_READ;
                2'd2:    h = wr ? H_HI_HIGH_ADDR : H_HI_READ;
                default: h = wr ? H_HI_DATA : H_HI_READ;
            endcase
            return h;
        end
    endfunction

    // Sixteen-port blaster window
    function automatic handler_t window_lookup(input logic [3:0] idx, input logic wr);
        handler_t h;
        begin
            case (idx)
                4'h0:    h = wr ? H_HI_LOW_ADDR : H_HI_READ;
                4'h1:    h = wr ? H_HI_DATA : H_HI_READ;
                4'h2:    h = wr ? H_HI_HIGH_ADDR : H_HI_READ;
                4'h3:    h = wr ? H_HI_DATA : H_HI_READ;
                4'h4:    h = H_IGNORE;
                4'h5:    h = wr ? H_MIXER_WRITE : H_DSP_READ;
                4'h6:    h = wr ? H_DSP_RESET : H_IGNORE;
                4'h8:    h = wr ? H_FM_ADDR : H_FM_READ;
                4'h9:    h = wr ? H_FM_DATA : H_FM_READ;
                4'hA:    h = wr ? H_IGNORE : H_DSP_READ;
                4'hC:    h = wr ? H_DSP_WRITE : H_DSP_WBUF;
                4'hE:    h = wr ? H_IGNORE : H_DSP_AVAIL;
                default: h = H_NONE;
            endcase
            return h;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/opl_sb_if.sv =====
`default_nettype none

// Request channel: one bus access per word
interface opl_sb_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] port;
    logic [7:0]  data_in;

    modport source (output valid, output cmd, output port, output data_in, input ready);
    modport sink   (input valid, input cmd, input port, input data_in, output ready);
endinterface

// Response channel: one result per access
interface opl_sb_rsp_if;
    logic       valid;
    logic       ready;
    logic       claimed;
    logic [7:0] read_data;
    logic       lpt_write;
    logic [7:0] lpt_data;
    logic [3:0] lpt_control;
    logic [5:0] settle_delay;
    logic       raise_irq;

    modport source (output valid, output claimed, output read_data, output lpt_write,
                    output lpt_data, output lpt_control, output settle_delay,
                    output raise_irq, input ready);
    modport sink   (input valid, input claimed, input read_data, input lpt_write,
                    input lpt_data, input lpt_control, input settle_delay,
                    input raise_irq, output ready);
endinterface

`default_nettype wire

// ===== sv/opl_sb_decode.sv =====
`default_nettype none

module opl_sb_decode (
    input  wire logic                [15:0] port,
    input  wire logic                       wr,
    input  wire logic                [15:0] window_base,
    output opl_sb_pkg::handler_t            handler
);
    import opl_sb_pkg::*;

    logic fixed_hit;
    logic window_hit;

    // Fixed ports win over an overlapping window
    assign fixed_hit  = (port[15:2] == FM_BASE_PORT[15:2]);
    assign window_hit = (window_base != 16'd0) && (window_base[3:0] == 4'd0)
                        && (port[15:4] == window_base[15:4]);

    always_comb
    begin
        if (fixed_hit)
        begin
            handler = fixed_lookup(port[1:0], wr);
        end
        else if (window_hit)
        begin
            handler = window_lookup(port[3:0], wr);
        end
        else
        begin
            handler = H_NONE;
        end
    end

endmodule

`default_nettype wire

// ===== sv/opl_sb_exec.sv =====
`default_nettype none

module opl_sb_exec (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire opl_sb_pkg::handler_t handler,
    input  wire logic                 wr,
    input  wire logic           [7:0] data_in,
    input  wire logic                 opl3_mode,
    input  wire logic                 delay_enable,
    output opl_sb_pkg::result_t       result
);
    import opl_sb_pkg::*;

    logic [8:0] sel_reg,    sel_next;
    logic [7:0] tctl_reg,   tctl_next;
    logic       await_reg,  await_next;
    logic [7:0] reply0_reg, reply0_next;
    logic [7:0] reply1_reg, reply1_next;

    logic [7:0] status;
    logic       lpt_w;
    logic [3:0] lpt_c;
    logic [5:0] lpt_dly;
    logic [7:0] rd;
    logic       irq;
    logic [5:0] data_dly;

    // Timers report expiry at once
    always_comb
    begin
        status = 8'd0;
        if ((tctl_reg & T1_MASK) == T1_MATCH)
        begin
            status = status | T1_FLAGS;
        end
        if ((tctl_reg & T2_MASK) == T2_MATCH)
        begin
            status = status | T2_FLAGS;
        end
        if (!opl3_mode)
        begin
            status = status | OPL2_ID_BITS;
        end
    end

    assign data_dly = opl3_mode ? DLY_SHORT : DLY_LONG;

    // Run the selected handler
    always_comb
    begin
        sel_next    = sel_reg;
        tctl_next   = tctl_reg;
        await_next  = await_reg;
        reply0_next = reply0_reg;
        reply1_next = reply1_reg;
        rd          = 8'd0;
        lpt_w       = 1'b0;
        lpt_c       = 4'd0;
        lpt_dly     = 6'd0;
        irq         = 1'b0;
        case (handler)
            H_IGNORE:
            begin
                rd = wr ? 8'd0 : data_in;
            end
            H_FM_READ:
            begin
                rd = status;
            end
            H_HI_READ:
            begin
                rd = opl3_mode ? status : 8'd0;
            end
            H_FM_ADDR, H_HI_LOW_ADDR:
            begin
                if (handler == H_FM_ADDR || opl3_mode)
                begin
                    sel_next = {1'b0, data_in};
                    lpt_w    = 1'b1;
                    lpt_c    = LPT_CTRL_ADDR;
                    lpt_dly  = DLY_SHORT;
                end
            end
            H_FM_DATA, H_HI_DATA:
            begin
                if (handler == H_FM_DATA || opl3_mode)
                begin
                    if (sel_reg == TIMER_CTRL_ADDR)
                    begin
                        tctl_next = data_in;
                    end
                    lpt_w   = 1'b1;
                    lpt_c   = LPT_CTRL_DATA;
                    lpt_dly = data_dly;
                end
            end
            H_HI_HIGH_ADDR:
            begin
                if (opl3_mode)
                begin
                    sel_next = {1'b1, data_in};
                    lpt_w    = 1'b1;
                    lpt_c    = LPT_CTRL_HIGH;
                    lpt_dly  = DLY_SHORT;
                end
            end
            H_DSP_READ:
            begin
                rd          = reply0_reg;
                reply0_next = reply1_reg;
            end
            H_MIXER_WRITE:
            begin
                reply0_next = data_in;
                reply1_next = data_in;
            end
            H_DSP_RESET:
            begin
                await_next  = 1'b0;
                reply0_next = DSP_RESET_REPLY;
                reply1_next = DSP_RESET_REPLY;
            end
            H_DSP_WRITE:
            begin
                if (await_reg)
                begin
                    reply0_next = ~data_in;
                    reply1_next = ~data_in;
                    await_next  = 1'b0;
                end
                else
                begin
                    case (data_in)
                        DSP_CMD_IDENT, DSP_CMD_DIRECT, DSP_CMD_MIDI, DSP_CMD_TCONST:
                        begin
                            await_next = 1'b1;
                        end
                        DSP_CMD_VERSION:
                        begin
                            reply0_next = opl3_mode ? VER_OPL3_MAJOR : VER_OPL2_MAJOR;
                            reply1_next = opl3_mode ? VER_OPL3_MINOR : VER_OPL2_MINOR;
                        end
                        DSP_CMD_IRQ:
                        begin
                            irq = 1'b1;
                        end
                        default:
                        begin
                            reply0_next = 8'd0;
                            reply1_next = 8'd0;
                        end
                    endcase
                end
            end
            H_DSP_WBUF:
            begin
                rd = 8'd0;
            end
            H_DSP_AVAIL:
            begin
                rd = AVAIL_FLAGS;
            end
            default:
            begin
            end
        endcase
    end

    // Pack the result word
    always_comb
    begin
        result.claimed      = (handler != H_NONE);
        result.read_data    = rd;
        result.lpt_write    = lpt_w;
        result.lpt_data     = lpt_w ? data_in : 8'd0;
        result.lpt_control  = lpt_c;
        result.settle_delay = delay_enable ? lpt_dly : 6'd0;
        result.raise_irq    = irq;
    end

    // Commit state when the access executes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg    <= 9'd0;
            tctl_reg   <= 8'd0;
            await_reg  <= 1'b0;
            reply0_reg <= DSP_RESET_REPLY;
            reply1_reg <= DSP_RESET_REPLY;
        end
        else if (fire)
        begin
            sel_reg    <= sel_next;
            tctl_reg   <= tctl_next;
            await_reg  <= await_next;
            reply0_reg <= reply0_next;
            reply1_reg <= reply1_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/opl_sb_port_access_emulator_top.sv =====
// FM synthesizer / blaster port access emulator.
//
// req carries one bus access per word: cmd (0 read, 1 write), port and
// data_in. rsp returns one result word for every access: claim flag, read
// byte, a parallel-port byte write with its control value and settle delay,
// and an interrupt request from the DSP stub.
// Configuration goes through cfg_we / cfg_index / cfg_data while no access
// is in flight: 0 window base, 1 OPL3 mode, 2 delay enable.
//
// An access is registered in the input register on acceptance; when the
// result register is free or being taken, the access executes and its
// result is computed and registered in the result register.
// One access per cycle is sustained while rsp does not stall.
// When rsp stalls the result holds and one more access can wait in the
// input register before req.ready drops.
// Reset empties both registers, clears the selected register, the timer
// control and the DSP operand-wait state, and loads 0xAA into both reply bytes.
`default_nettype none

module opl_sb_port_access_emulator_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    opl_sb_req_if.sink        req,
    opl_sb_rsp_if.source      rsp,
    input  wire logic         cfg_we,
    input  wire logic   [1:0] cfg_index,
    input  wire logic  [15:0] cfg_data
);
    import opl_sb_pkg::*;

    logic [15:0] base_reg;
    logic        opl3_reg;
    logic        delay_reg;

    logic        s1_valid_reg;
    logic        s1_wr_reg;
    logic [15:0] s1_port_reg;
    logic [7:0]  s1_data_reg;
    logic        s2_valid_reg;
    result_t     s2_res_reg;

    logic        s1_load;
    logic        s2_load;
    logic        fire;
    handler_t    handler;
    result_t     res_next;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= 16'd0;
            opl3_reg  <= 1'b0;
            delay_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SB_BASE: base_reg  <= cfg_data;
                CFG_OPL3:    opl3_reg  <= cfg_data[0];
                CFG_DELAY:   delay_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Advance the two stages
    assign s2_load   = !s2_valid_reg || rsp.ready;
    assign s1_load   = !s1_valid_reg || s2_load;
    assign fire      = s1_valid_reg && s2_load;
    assign req.ready = s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Hold the accepted access
    always_ff @(posedge clk)
    begin
        if (s1_load && req.valid)
        begin
            s1_wr_reg   <= req.cmd;
            s1_port_reg <= req.port;
            s1_data_reg <= req.data_in;
        end
    end

    opl_sb_decode u_decode (
        .port        (s1_port_reg),
        .wr          (s1_wr_reg),
        .window_base (base_reg),
        .handler     (handler)
    );

    opl_sb_exec u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .handler      (handler),
        .wr           (s1_wr_reg),
        .data_in      (s1_data_reg),
        .opl3_mode    (opl3_reg),
        .delay_enable (delay_reg),
        .result       (res_next)
    );

    // Hold the result word
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s2_res_reg <= res_next;
        end
    end

    assign rsp.valid        = s2_valid_reg;
    assign rsp.claimed      = s2_res_reg.claimed;
    assign rsp.read_data    = s2_res_reg.read_data;
    assign rsp.lpt_write    = s2_res_reg.lpt_write;
    assign rsp.lpt_data     = s2_res_reg.lpt_data;
    assign rsp.lpt_control  = s2_res_reg.lpt_control;
    assign rsp.settle_delay = s2_res_reg.settle_delay;
    assign rsp.raise_irq    = s2_res_reg.raise_irq;

    // A forwarded byte or an interrupt only comes from a claimed port
    a_lpt_claimed: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.lpt_write || rsp.raise_irq)) |-> rsp.claimed)
        else $error("forwarded byte or irq from unclaimed port");

    // A delay is requested only for a forwarded byte with delays enabled
    a_delay_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.settle_delay != 6'd0) |-> (rsp.lpt_write && delay_reg))
        else $error("settle delay without forwarded write");

    // Writes never return read data
    a_write_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_wr_reg) |-> (res_next.read_data == 8'd0))
        else $error("read data on a write access");

    // An executed access shows up as a result on the next edge
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> s2_valid_reg)
        else $error("executed access lost");

    // Input stage full and result stalled blocks the request channel
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("access taken while both stages are full");

endmodule

`default_nettype wire

// ===== test/access_check_pkg.sv =====
`timescale 1ns / 1ps

package access_check_pkg;
    import opl_sb_pkg::*;

    // Port emulator predictor plus the queue of result words still owed
    class access_scoreboard;
        logic [15:0] win_base;
        bit          opl3_on;
        bit          delay_on;
        logic [8:0]  sel_reg;
        logic [7:0]  timer_ctl;
        bit          dsp_wait;
        logic [7:0]  dsp_reply [2];
        result_t     expected_results [$];
        int          failures;

        function new();
            win_base     = '0;
            opl3_on      = 1'b0;
            delay_on     = 1'b0;
            sel_reg      = '0;
            timer_ctl    = '0;
            dsp_wait     = 1'b0;
            dsp_reply[0] = DSP_RESET_REPLY;
            dsp_reply[1] = DSP_RESET_REPLY;
            failures     = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [15:0] value);
            case (idx)
                CFG_SB_BASE: win_base = value;
                CFG_OPL3:    opl3_on  = value[0];
                CFG_DELAY:   delay_on = value[0];
                default:     ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Timers always read as expired once started and unmasked
        function logic [7:0] timer_status();
            logic [7:0] s;
            s = '0;
            if ((timer_ctl & T1_MASK) == T1_MATCH)
                s |= T1_FLAGS;
            if ((timer_ctl & T2_MASK) == T2_MATCH)
                s |= T2_FLAGS;
            if (!opl3_on)
                s |= OPL2_ID_BITS;
            return s;
        endfunction

        function void lpt_word(inout result_t r, input logic [7:0] d,
                               input logic [3:0] ctrl, input logic [5:0] dly);
            r.lpt_write    = 1'b1;
            r.lpt_data     = d;
            r.lpt_control  = ctrl;
            r.settle_delay = delay_on ? dly : 6'd0;
        endfunction

        function void fm_address(inout result_t r, input logic [7:0] d);
            sel_reg = {1'b0, d};
            lpt_word(r, d, LPT_CTRL_ADDR, DLY_SHORT);
        endfunction

        function void fm_data(inout result_t r, input logic [7:0] d);
            if (sel_reg == TIMER_CTRL_ADDR)
                timer_ctl = d;
            lpt_word(r, d, LPT_CTRL_DATA, opl3_on ? DLY_SHORT : DLY_LONG);
        endfunction

        // Decode one accepted access, update state and queue its result word
        function void predict_access(logic wr, logic [15:0] port, logic [7:0] d);
            handler_t h;
            result_t  r;
            h = H_NONE;
            r = '0;
            // fixed FM ports win over an overlapping window
            if (port[15:2] == FM_BASE_PORT[15:2]) begin
                case ({port[1:0], wr})
                    3'b00_0, 3'b01_0: h = H_FM_READ;
                    3'b00_1:          h = H_FM_ADDR;
                    3'b01_1:          h = H_FM_DATA;
                    3'b10_0, 3'b11_0: h = H_HI_READ;
                    3'b10_1:          h = H_HI_HIGH_ADDR;
                    default:          h = H_HI_DATA;
                endcase
            end
            else if (win_base != 16'h0000 && {port[15:4], 4'h0} == win_base) begin
                case ({port[3:0], wr})
                    5'h00, 5'h02, 5'h04, 5'h06: h = H_HI_READ;
                    5'h01:                      h = H_HI_LOW_ADDR;
                    5'h03, 5'h07:               h = H_HI_DATA;
                    5'h05:                      h = H_HI_HIGH_ADDR;
                    5'h08, 5'h09, 5'h0C, 5'h15: h = H_IGNORE;
                    5'h1D:                      h = H_IGNORE;
                    5'h0A, 5'h14:               h = H_DSP_READ;
                    5'h0B:                      h = H_MIXER_WRITE;
                    5'h0D:                      h = H_DSP_RESET;
                    5'h10:                      h = H_FM_READ;
                    5'h11:                      h = H_FM_ADDR;
                    5'h12:                      h = H_FM_READ;
                    5'h13:                      h = H_FM_DATA;
                    5'h18:                      h = H_DSP_WBUF;
                    5'h19:                      h = H_DSP_WRITE;
                    5'h1C:                      h = H_DSP_AVAIL;
                    default:                    h = H_NONE;
                endcase
            end

            r.claimed = (h != H_NONE);
            case (h)
                H_IGNORE:       if (!wr) r.read_data = d;
                H_FM_READ:      r.read_data = timer_status();
                H_HI_READ:      r.read_data = opl3_on ? timer_status() : 8'h00;
                H_FM_ADDR:      fm_address(r, d);
                H_FM_DATA:      fm_data(r, d);
                H_HI_LOW_ADDR:  if (opl3_on) fm_address(r, d);
                H_HI_HIGH_ADDR:
                begin
                    if (opl3_on) begin
                        sel_reg = {1'b1, d};
                        lpt_word(r, d, LPT_CTRL_HIGH, DLY_SHORT);
                    end
                end
                H_HI_DATA:      if (opl3_on) fm_data(r, d);
                H_DSP_READ:
                begin
                    r.read_data  = dsp_reply[0];
                    dsp_reply[0] = dsp_reply[1];
                end
                H_MIXER_WRITE:
                begin
                    dsp_reply[0] = d;
                    dsp_reply[1] = d;
                end
                H_DSP_RESET:
                begin
                    dsp_wait     = 1'b0;
                    dsp_reply[0] = DSP_RESET_REPLY;
                    dsp_reply[1] = DSP_RESET_REPLY;
                end
                H_DSP_WRITE:
                begin
                    // an operand byte is answered with its complement
                    if (dsp_wait) begin
                        dsp_reply[0] = ~d;
                        dsp_reply[1] = ~d;
                        dsp_wait     = 1'b0;
                    end
                    else begin
                        case (d)
                            DSP_CMD_IDENT, DSP_CMD_DIRECT, DSP_CMD_MIDI, DSP_CMD_TCONST:
                                dsp_wait = 1'b1;
                            DSP_CMD_VERSION:
                            begin
                                dsp_reply[0] = opl3_on ? VER_OPL3_MAJOR : VER_OPL2_MAJOR;
                                dsp_reply[1] = opl3_on ? VER_OPL3_MINOR : VER_OPL2_MINOR;
                            end
                            DSP_CMD_IRQ:
                                r.raise_irq = 1'b1;
                            default:
                            begin
                                dsp_reply[0] = 8'h00;
                                dsp_reply[1] = 8'h00;
                            end
                        endcase
                    end
                end
                H_DSP_WBUF:     r.read_data = 8'h00;
                H_DSP_AVAIL:    r.read_data = AVAIL_FLAGS;
                default:        ;
            endcase
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        endfunction

        // Compare one accepted result word with the oldest one owed
        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result word 0x%0h with no access outstanding", got);
                return;
            end
            want = expected_results.pop_front();
            compare_field("claimed", want.claimed, got.claimed);
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("lpt_write", want.lpt_write, got.lpt_write);
            compare_field("lpt_data", want.lpt_data, got.lpt_data);
            compare_field("lpt_control", want.lpt_control, got.lpt_control);
            compare_field("settle_delay", want.settle_delay, got.settle_delay);
            compare_field("raise_irq", want.raise_irq, got.raise_irq);
        endfunction
    endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import opl_sb_pkg::*;
    import access_check_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    opl_sb_req_if req_ch ();
    opl_sb_rsp_if rsp_ch ();

    access_scoreboard sb;
    logic [15:0]      cur_base;
    bit               sender_gaps;
    bit               sink_stalls;
    bit               hold_request;
    int               hold_left;
    int               items_sent;
    int               cycles;

    opl_sb_port_access_emulator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("no progress after %0d cycles", cycles);
        $display("Verification failed");
        $finish;
    end

    // Result side: check accepted words, stall at random, hold off on request
    initial
    begin
        result_t seen;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                seen.claimed      = rsp_ch.claimed;
                seen.read_data    = rsp_ch.read_data;
                seen.lpt_write    = rsp_ch.lpt_write;
                seen.lpt_data     = rsp_ch.lpt_data;
                seen.lpt_control  = rsp_ch.lpt_control;
                seen.settle_delay = rsp_ch.settle_delay;
                seen.raise_irq    = rsp_ch.raise_irq;
                sb.check_result(seen);
            end
            @(negedge clk);
            if (hold_request) begin
                hold_left    = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else begin
                rsp_ch.ready <= !(sink_stalls && $urandom_range(99) < 22);
            end
        end
    end

    function automatic logic [15:0] window_port(logic [3:0] idx);
        return {cur_base[15:4], idx};
    endfunction

    // Offer one access word and hold it until taken
    task automatic send_access(logic wr, logic [15:0] p, logic [7:0] d);
        @(negedge clk);
        while (sender_gaps && $urandom_range(99) < 22) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.cmd     <= wr;
        req_ch.port    <= p;
        req_ch.data_in <= d;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.predict_access(wr, p, d);
        items_sent++;
    endtask

    // Drop valid and wait until every result word has come back
    task automatic quiesce();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_settings(logic [15:0] base, logic opl3, logic dly);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SB_BASE;
        cfg_data  <= base;
        @(negedge clk);
        cfg_index <= CFG_OPL3;
        cfg_data  <= {15'h0000, opl3};
        @(negedge clk);
        cfg_index <= CFG_DELAY;
        cfg_data  <= {15'h0000, dly};
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_register(CFG_SB_BASE, base);
        sb.set_register(CFG_OPL3, {15'h0000, opl3});
        sb.set_register(CFG_DELAY, {15'h0000, dly});
        cur_base = base;
    endtask

    // Mostly register sequences and DSP exchanges, some single and stray accesses
    task automatic run_random_traffic(int count);
        int          stop;
        int          pick;
        logic [7:0]  value;
        logic [15:0] addr_port;
        logic [15:0] data_port;
        stop = items_sent + count;
        while (items_sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                value = ($urandom_range(2) == 0) ? 8'h04 : 8'($urandom);
                case ($urandom_range(3))
                    0:
                    begin
                        addr_port = FM_BASE_PORT;
                        data_port = FM_BASE_PORT + 16'd1;
                    end
                    1:
                    begin
                        addr_port = window_port(4'h8);
                        data_port = window_port(4'h9);
                    end
                    2:
                    begin
                        addr_port = window_port(4'h0);
                        data_port = window_port($urandom_range(1) ? 4'h1 : 4'h3);
                    end
                    default:
                    begin
                        addr_port = $urandom_range(1) ? FM_BASE_PORT + 16'd2 : window_port(4'h2);
                        data_port = $urandom_range(1) ? FM_BASE_PORT + 16'd3 : window_port(4'h3);
                    end
                endcase
                send_access(1'b1, addr_port, value);
                send_access(1'b1, data_port, 8'($urandom));
                send_access(1'b0, $urandom_range(1) ? FM_BASE_PORT + 16'($urandom_range(3))
                                                    : window_port(4'($urandom_range(3))),
                            8'($urandom));
            end
            else if (pick < 45) begin
                case ($urandom_range(6))
                    0:       value = DSP_CMD_IDENT;
                    1:       value = DSP_CMD_DIRECT;
                    2:       value = DSP_CMD_MIDI;
                    3:       value = DSP_CMD_TCONST;
                    4:       value = DSP_CMD_VERSION;
                    5:       value = DSP_CMD_IRQ;
                    default: value = 8'($urandom);
                endcase
                send_access(1'b1, window_port(4'hC), value);
                if ($urandom_range(4) != 0)
                    send_access(1'b1, window_port(4'hC), 8'($urandom));
                repeat ($urandom_range(1, 3))
                    send_access(1'b0, window_port($urandom_range(1) ? 4'hA : 4'h5),
                                8'($urandom));
            end
            else if (pick < 55) begin
                send_access(1'b1, window_port(4'h5), 8'($urandom));
                repeat ($urandom_range(1, 2))
                    send_access(1'b0, window_port($urandom_range(1) ? 4'hA : 4'h5),
                                8'($urandom));
            end
            else if (pick < 60) begin
                send_access(1'b1, window_port(4'h6), 8'($urandom));
                send_access(1'b0, window_port(4'hA), 8'($urandom));
                send_access(1'b0, window_port($urandom_range(1) ? 4'hC : 4'hE), 8'($urandom));
            end
            else if (pick < 85) begin
                if ($urandom_range(1))
                    send_access(1'($urandom), FM_BASE_PORT + 16'($urandom_range(3)),
                                8'($urandom));
                else
                    send_access(1'($urandom), window_port(4'($urandom)), 8'($urandom));
            end
            else begin
                send_access(1'($urandom), 16'($urandom), 8'($urandom));
            end
        end
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_SB_BASE;
        cfg_data       = 16'h0000;
        req_ch.valid   = 1'b0;
        req_ch.cmd     = 1'b0;
        req_ch.port    = 16'h0000;
        req_ch.data_in = 8'h00;
        rsp_ch.ready   = 1'b0;
        sender_gaps    = 1'b1;
        sink_stalls    = 1'b1;
        hold_request   = 1'b0;
        items_sent     = 0;
        cur_base       = 16'h0000;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: timer status, high ports in two-operator mode, DSP stub
        apply_settings(16'h0220, 1'b0, 1'b1);
        send_access(1'b0, 16'h0388, 8'h00);
        send_access(1'b1, 16'h0388, 8'h04);
        send_access(1'b1, 16'h0389, 8'h01);
        send_access(1'b0, 16'h0389, 8'hFF);
        send_access(1'b1, 16'h0389, 8'h02);
        send_access(1'b1, 16'h038A, 8'hFF);
        send_access(1'b0, 16'h038B, 8'h00);
        send_access(1'b1, 16'h022C, DSP_CMD_VERSION);
        send_access(1'b0, 16'h022A, 8'h00);
        send_access(1'b0, 16'h022A, 8'h00);
        send_access(1'b1, 16'h022C, DSP_CMD_IDENT);
        send_access(1'b1, 16'h022C, 8'h5A);
        send_access(1'b0, 16'h022A, 8'h00);
        send_access(1'b1, 16'h022C, DSP_CMD_IRQ);
        send_access(1'b1, 16'h022C, 8'h00);
        send_access(1'b0, 16'h022A, 8'h00);
        send_access(1'b1, 16'h0225, 8'h3C);
        send_access(1'b0, 16'h0225, 8'h00);
        send_access(1'b1, 16'h0226, 8'hFF);
        send_access(1'b0, 16'h022A, 8'h00);
        send_access(1'b0, 16'h0224, 8'h5B);
        send_access(1'b1, 16'h022A, 8'h77);
        send_access(1'b0, 16'h022E, 8'h00);
        send_access(1'b0, 16'h022C, 8'h00);
        send_access(1'b0, 16'h0227, 8'h00);
        send_access(1'b1, 16'hFFFF, 8'hFF);
        send_access(1'b0, 16'h0000, 8'h00);
        run_random_traffic(260);

        // Back to back on both sides
        apply_settings(16'h0240, 1'b1, 1'b0);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        run_random_traffic(260);
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;

        // Top window base; result side holds off so the input backs up
        apply_settings(16'hFFF0, 1'b1, 1'b1);
        hold_request = 1'b1;
        run_random_traffic(260);

        // Window overlapping the fixed FM ports
        apply_settings(16'h0380, 1'b0, 1'b0);
        run_random_traffic(220);

        // Unaligned base never matches
        apply_settings(16'h02A5, 1'b1, 1'b1);
        run_random_traffic(170);

        // Window disabled
        apply_settings(16'h0000, 1'b0, 1'b0);
        run_random_traffic(160);

        quiesce();
        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
